// ===== rtl/lpr_pkg.sv =====
// Shared types and constants of the line pixel rasteriser.
package lpr_pkg;

  localparam int unsigned COORD_W     = 6;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned ERR_W       = 8;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Register byte addresses.
  localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_HEIGHT = 3'd4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // One classified line, ready for the stepper.
  typedef struct packed {
    coord_t                     major;
    coord_t                     minor;
    coord_t                     major_end;
    err_t                       err;
    err_t                       inc_flat;
    err_t                       inc_diag;
    logic                       steep;
    logic                       minor_up;
    logic [COLOR_W-1:0]         color;
  } line_cmd_t;

  // Surface configuration as seen by the stepper.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } lpr_cfg_t;

endpackage

// ===== rtl/lpr_front.sv =====
// Front end: accepts a line segment and classifies it into a stepping command.
module lpr_front
  import lpr_pkg::*;
(
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // fields from bit 0: start_x, start_y, end_x, end_y, line_color
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output line_cmd_t            push_cmd_o
);

  coord_t            x1, y1, x2, y2;
  logic [COORD_W:0]  dx, dy;
  coord_t            adx, ady;
  coord_t            amaj, amin;
  logic              steep;
  logic [ERR_W-1:0]  two_min, two_maj;

  assign x1 = s_axis_tdata[5:0];
  assign y1 = s_axis_tdata[11:6];
  assign x2 = s_axis_tdata[17:12];
  assign y2 = s_axis_tdata[23:18];

  always_comb begin
    dx    = {1'b0, x2} - {1'b0, x1};
    dy    = {1'b0, y2} - {1'b0, y1};
    adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    steep = ady > adx;
    amaj  = steep ? ady : adx;
    amin  = steep ? adx : ady;
    two_min = {1'b0, amin, 1'b0};
    two_maj = {1'b0, amaj, 1'b0};

    push_cmd_o.steep = steep;
    // The minor coordinate rises when both deltas are non-zero and share a sign.
    push_cmd_o.minor_up = (dx[COORD_W] && dy[COORD_W]) ||
                          (!dx[COORD_W] && (dx != '0) && !dy[COORD_W] && (dy != '0));
    if (steep) begin
      push_cmd_o.major     = dy[COORD_W] ? y2 : y1;
      push_cmd_o.minor     = dy[COORD_W] ? x2 : x1;
      push_cmd_o.major_end = dy[COORD_W] ? y1 : y2;
    end else begin
      push_cmd_o.major     = dx[COORD_W] ? x2 : x1;
      push_cmd_o.minor     = dx[COORD_W] ? y2 : y1;
      push_cmd_o.major_end = dx[COORD_W] ? x1 : x2;
    end
    push_cmd_o.err      = err_t'(two_min - {2'b00, amaj});
    push_cmd_o.inc_flat = err_t'(two_min);
    push_cmd_o.inc_diag = err_t'(two_min - two_maj);
    push_cmd_o.color    = s_axis_tdata[47:24];
  end

  assign push_valid_o  = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

// ===== rtl/lpr_queue.sv =====
// Short command queue between the front end and the stepper.
module lpr_queue
  import lpr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  line_cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output line_cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  line_cmd_t          entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/lpr_stepper.sv =====
// Back end: Bresenham stepper that emits one pixel per cycle into an output register while the output is not stalled.
module lpr_stepper
  import lpr_pkg::*;
#(
  parameter int unsigned TILE_SIZE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpr_cfg_t              cfg_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  line_cmd_t             cmd_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fields from bit 0: pixel_x, pixel_y, pixel_address, pixel_color
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // fields from bit 0: in_bounds
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam logic [DIM_W-1:0] TILE_DIM = DIM_W'(TILE_SIZE);

  logic                    busy_q, busy_d;
  logic                    tvalid_q, tvalid_d;
  line_cmd_t               line_q;
  logic [OUT_DATA_W-1:0]   tdata_q;
  logic                    tuser_q;
  logic                    tlast_q;

  logic [DIM_W-1:0]        w_eff, h_eff;
  coord_t                  px, py;
  logic [COORD_W+DIM_W-1:0] row_base;
  logic [COORD_W+DIM_W-1:0] addr_sum;
  logic                    in_bounds;
  logic                    last;
  logic                    load;
  logic                    step_flat;

  always_comb begin
    w_eff     = (cfg_i.width > TILE_DIM) ? TILE_DIM : cfg_i.width;
    h_eff     = (cfg_i.height > TILE_DIM) ? TILE_DIM : cfg_i.height;
    px        = line_q.steep ? line_q.minor : line_q.major;
    py        = line_q.steep ? line_q.major : line_q.minor;
    row_base  = py * w_eff;
    addr_sum  = row_base + {{DIM_W{1'b0}}, px};
    in_bounds = ({1'b0, px} < w_eff) && ({1'b0, py} < h_eff);
    last      = line_q.major >= line_q.major_end;
    // Shallow lines keep the minor coordinate while the error is negative,
    // steep lines also while it is zero.
    step_flat = line_q.steep ? (line_q.err <= 0) : (line_q.err < 0);
  end

  assign load        = busy_q && (!tvalid_q || m_axis_tready);
  assign cmd_ready_o = !busy_q;

  always_comb begin
    busy_d   = busy_q;
    tvalid_d = tvalid_q;
    if (!busy_q && cmd_valid_i) begin
      busy_d = 1'b1;
    end else if (load && last) begin
      busy_d = 1'b0;
    end
    if (load) begin
      tvalid_d = 1'b1;
    end else if (m_axis_tready) begin
      tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      tvalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      tvalid_q <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && cmd_valid_i) begin
      line_q <= cmd_i;
    end else if (load && !last) begin
      line_q.major <= line_q.major + 1'b1;
      if (step_flat) begin
        line_q.err <= line_q.err + line_q.inc_flat;
      end else begin
        line_q.minor <= line_q.minor_up ? line_q.minor + 1'b1 : line_q.minor - 1'b1;
        line_q.err   <= line_q.err + line_q.inc_diag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tdata_q <= {line_q.color, addr_sum[ADDR_W-1:0], py, px};
      tuser_q <= in_bounds;
      tlast_q <= last;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tlast  = tlast_q;

endmodule

// ===== rtl/line_pixel_rasterizer.sv =====
// Top level of the line pixel rasteriser with its configuration registers.
//
// Usage: each item on the s_axis channel is one line segment (two endpoints
// and a colour). The block answers with one m_axis item per pixel of the
// line, in stepping order; tlast marks the final pixel and tuser carries the
// in-bounds flag. Surface width and height are set through the APB port,
// only while no line is in flight: a rule for the user, not enforced.
//
// The front end classifies a segment in the cycle it is accepted and places
// it in a two-entry queue. From there it passes through the stepper's line
// register and the output register. For a line of n pixels (n from 1
// to 64) the stepper first loads the command from the queue, then emits one
// pixel per cycle from its single Bresenham update loop unless stalled.
//
// Reset sets width and height to 64 and empties the queue and the output
// register. When the receiver holds tready low, the pixel in the output
// register stays, the stepper stops, and once the queue is full s_axis_tready
// falls until the stepper takes the next line.
module line_pixel_rasterizer
  import lpr_pkg::*;
#(
  parameter int unsigned TILE_SIZE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // fields from bit 0: start_x, start_y, end_x, end_y, line_color
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fields from bit 0: pixel_x, pixel_y, pixel_address, pixel_color
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // fields from bit 0: in_bounds
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  lpr_cfg_t   cfg_q;
  logic       cfg_wr;
  logic       push_valid, push_ready;
  line_cmd_t  push_cmd;
  logic       pop_valid, pop_ready;
  line_cmd_t  pop_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= DIM_RESET;
      cfg_q.height <= DIM_RESET;
    end else if (cfg_wr) begin
      case (paddr)
        REG_SURFACE_WIDTH:  cfg_q.width  <= pwdata[DIM_W-1:0];
        REG_SURFACE_HEIGHT: cfg_q.height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_SURFACE_WIDTH:  prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, cfg_q.width};
      REG_SURFACE_HEIGHT: prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, cfg_q.height};
      default:            prdata = '0;
    endcase
  end

  lpr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  lpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  lpr_stepper #(
    .TILE_SIZE (TILE_SIZE)
  ) u_stepper (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (pop_valid),
    .cmd_ready_o   (pop_ready),
    .cmd_i         (pop_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/lpr_checker.sv =====
// Port-level checks on the pixel stream of the rasteriser, bound to the top level.
module lpr_checker
  import lpr_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  logic               mid_line_q;
  coord_t             prev_x_q, prev_y_q;
  logic [COLOR_W-1:0] prev_color_q;
  coord_t             cur_x, cur_y;
  coord_t             next_x, next_y, back_x, back_y;
  logic               major_step, minor_ok;

  always_comb begin
    cur_x      = m_axis_tdata[5:0];
    cur_y      = m_axis_tdata[11:6];
    next_x     = prev_x_q + 1'b1;
    next_y     = prev_y_q + 1'b1;
    back_x     = prev_x_q - 1'b1;
    back_y     = prev_y_q - 1'b1;
    // Along a line the major axis advances by one; the other moves by one at most.
    major_step = (cur_x == next_x) || (cur_y == next_y);
    minor_ok   = ((cur_x == prev_x_q) || (cur_x == next_x) || (cur_x == back_x)) &&
                 ((cur_y == prev_y_q) || (cur_y == next_y) || (cur_y == back_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_line_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      mid_line_q <= !m_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      prev_x_q     <= cur_x;
      prev_y_q     <= cur_y;
      prev_color_q <= m_axis_tdata[47:24];
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("pixel changed while stalled");

  a_step_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mid_line_q |-> major_step && minor_ok)
    else $error("pixel is not adjacent to the previous pixel of its line");

  a_color_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mid_line_q |-> m_axis_tdata[47:24] == prev_color_q)
    else $error("colour changed within a line");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);
